// ===== hdl/sgm_pkg.sv =====
`default_nettype none
// ============================================================================
// sgm_pkg
// Shared widths, register indexes, state type and defaults for the Sobel
// gradient magnitude unit.
// ============================================================================
package sgm_pkg;

    // pixel and result field widths
    localparam int PIX_W  = 8;
    localparam int GRAD_W = 11;
    localparam int ABS_W  = GRAD_W - 1;
    localparam int SQ_W   = 21;
    localparam int MAG_W  = 11;
    localparam int POS_W  = 6;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // geometry
    localparam int WIN_SIZE = 3;
    localparam int MIN_DIM  = 3;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 7'd64;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 7'd64;

    // square root: one result bit per step
    localparam int ROOT_STEPS = (SQ_W + 1) / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    // pixel sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } t_state;

endpackage : sgm_pkg
`default_nettype wire

// ===== hdl/sgm_isqrt.sv =====
`default_nettype none
// ============================================================================
// sgm_isqrt
// Floor integer square root, one result bit per cycle (digit by digit,
// compare-and-subtract remainder form).
// ============================================================================
module sgm_isqrt (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [sgm_pkg::SQ_W-1:0] i_radicand,
    output logic                          o_done,
    output logic [sgm_pkg::MAG_W-1:0]     o_root
);
    import sgm_pkg::*;

    localparam logic [SQ_W-1:0] BIT_START = SQ_W'(1) << (2 * (ROOT_STEPS - 1));

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SQ_W-1:0]   r_rem;
    logic [SQ_W:0]     r_res;
    logic [SQ_W-1:0]   r_bit;

    logic [SQ_W:0]     trial;
    logic              take;

    // trial subtraction for the current digit
    assign trial = r_res + {1'b0, r_bit};
    assign take  = ({1'b0, r_rem} >= trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(ROOT_STEPS - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_radicand;
            r_res <= '0;
            r_bit <= BIT_START;
        end else if (r_busy) begin
            if (take) begin
                r_rem <= r_rem - trial[SQ_W-1:0];
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[MAG_W-1:0];

endmodule : sgm_isqrt
`default_nettype wire

// ===== hdl/sobel_gradient_magnitude_unit.sv =====
`default_nettype none
// ============================================================================
// sobel_gradient_magnitude_unit
// 3x3 Sobel gradient, squared magnitude, integer magnitude and per-frame
// max / min-nonzero statistics over a raster pixel stream.
// ============================================================================
// One pixel is taken at a time. Two previous rows sit in one line memory (one
// 16-bit entry per column, read as the pixel is taken and written back the
// cycle after), and a 3x3 window is formed from it and six window registers.
// A pixel completing no window ends in the read state; one completing a window
// then runs the square, sum, root and done states, the root state waiting on
// the square-root unit, which resolves one bit of the 11-bit magnitude per
// cycle. The result sits in an output register, so the next pixel is taken
// while it waits. Frame width and height are clamped to 3..MAX_WIDTH and
// 3..MAX_HEIGHT; the line memory needs no clearing after reset.
module sobel_gradient_magnitude_unit #(
    parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sgm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [sgm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pixel input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [sgm_pkg::PIX_W-1:0]       i_pixel,
    // result output
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [sgm_pkg::POS_W-1:0]            o_out_row,
    output logic [sgm_pkg::POS_W-1:0]            o_out_col,
    output logic signed [sgm_pkg::GRAD_W-1:0]    o_grad_x,
    output logic signed [sgm_pkg::GRAD_W-1:0]    o_grad_y,
    output logic [sgm_pkg::SQ_W-1:0]             o_mag_squared,
    output logic [sgm_pkg::MAG_W-1:0]            o_magnitude,
    output logic [sgm_pkg::SQ_W-1:0]             o_frame_max_sq,
    output logic [sgm_pkg::SQ_W-1:0]             o_frame_min_sq,
    output logic                                 o_last_of_frame
);
    import sgm_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WD_W  = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ?
                           $clog2(MAX_WIDTH + 1) : CFG_DATA_W;
    localparam int HD_W  = ($clog2(MAX_HEIGHT + 1) > CFG_DATA_W) ?
                           $clog2(MAX_HEIGHT + 1) : CFG_DATA_W;
    localparam int COL_X_W = (COL_W > POS_W) ? COL_W : POS_W;
    localparam int ROW_X_W = (ROW_W > POS_W) ? ROW_W : POS_W;
    localparam int LINE_W  = 2 * PIX_W;
    localparam int SUM_W   = PIX_W + 2;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] r_cfg_width;
    logic [CFG_DATA_W-1:0] r_cfg_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_FRAME_WIDTH;
            r_cfg_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [WD_W-1:0] width_raw, width_eff;
    logic [HD_W-1:0] height_raw, height_eff;

    assign width_raw  = WD_W'(r_cfg_width);
    assign height_raw = HD_W'(r_cfg_height);
    assign width_eff  = (width_raw < WD_W'(MIN_DIM))   ? WD_W'(MIN_DIM)   :
                        (width_raw > WD_W'(MAX_WIDTH)) ? WD_W'(MAX_WIDTH) : width_raw;
    assign height_eff = (height_raw < HD_W'(MIN_DIM))    ? HD_W'(MIN_DIM)    :
                        (height_raw > HD_W'(MAX_HEIGHT)) ? HD_W'(MAX_HEIGHT) : height_raw;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    logic   in_accept;
    logic   item_read;
    logic   root_start;
    logic   out_load;
    logic   root_done;
    logic   r_item_emit;
    logic   r_out_valid;

    // control outputs
    always_comb begin
        in_accept  = 1'b0;
        item_read  = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                in_accept  = i_in_valid;
            end
            ST_READ:   item_read  = 1'b1;
            ST_SUM:    root_start = 1'b1;
            ST_DONE:   out_load   = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_READ;
            ST_READ:   n_state = r_item_emit ? ST_SQUARE : ST_IDLE;
            ST_SQUARE: n_state = ST_SUM;
            ST_SUM:    n_state = ST_ROOT;
            ST_ROOT:   if (root_done) n_state = ST_DONE;
            ST_DONE:   if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // position counters and per-pixel flags
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [WD_W-1:0]  col_ext;
    logic [HD_W-1:0]  row_ext;
    logic             row_end, frame_end, emit;

    assign col_ext   = WD_W'(r_col);
    assign row_ext   = HD_W'(r_row);
    assign row_end   = (col_ext + WD_W'(1)) >= width_eff;
    assign frame_end = row_end && ((row_ext + HD_W'(1)) >= height_eff);
    assign emit      = (row_ext >= HD_W'(WIN_SIZE - 1)) && (col_ext >= WD_W'(WIN_SIZE - 1))
                       && (col_ext < width_eff) && (row_ext < height_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // item being worked on
    logic [PIX_W-1:0] r_item_px;
    logic [COL_W-1:0] r_item_col;
    logic [ROW_W-1:0] r_item_row;
    logic             r_item_fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_emit <= 1'b0;
            r_item_fend <= 1'b0;
        end else if (in_accept) begin
            r_item_emit <= emit;
            r_item_fend <= frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item_px  <= i_pixel;
            r_item_col <= r_col;
            r_item_row <= r_row;
        end
    end

    // ------------------------------------------------------------------
    // line memory: [15:8] two rows up, [7:0] one row up
    // ------------------------------------------------------------------
    logic [LINE_W-1:0] r_line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_line_rd;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_line_rd <= r_line_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_read) begin
            r_line_mem[r_item_col] <= {r_line_rd[PIX_W-1:0], r_item_px};
        end
    end

    // ------------------------------------------------------------------
    // window and Sobel kernels
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_win [WIN_SIZE][2];
    logic [PIX_W-1:0] col_new [WIN_SIZE];

    assign col_new[0] = r_line_rd[LINE_W-1:PIX_W];
    assign col_new[1] = r_line_rd[PIX_W-1:0];
    assign col_new[2] = r_item_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_SIZE; i++) begin
                r_win[i][0] <= '0;
                r_win[i][1] <= '0;
            end
        end else if (item_read) begin
            for (int i = 0; i < WIN_SIZE; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= col_new[i];
            end
        end
    end

    // weighted 1-2-1 sums of the window edges
    logic [SUM_W-1:0] sum_left, sum_right, sum_top, sum_bottom;
    logic signed [GRAD_W-1:0] gx, gy;

    assign sum_left   = SUM_W'(r_win[0][0]) + {1'b0, r_win[1][0], 1'b0} + SUM_W'(r_win[2][0]);
    assign sum_right  = SUM_W'(col_new[0]) + {1'b0, col_new[1], 1'b0} + SUM_W'(col_new[2]);
    assign sum_top    = SUM_W'(r_win[0][0]) + {1'b0, r_win[0][1], 1'b0} + SUM_W'(col_new[0]);
    assign sum_bottom = SUM_W'(r_win[2][0]) + {1'b0, r_win[2][1], 1'b0} + SUM_W'(col_new[2]);
    assign gx = $signed({1'b0, sum_right})  - $signed({1'b0, sum_left});
    assign gy = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});

    logic signed [GRAD_W-1:0] r_gx, r_gy;

    always_ff @(posedge i_clk) begin
        if (item_read) begin
            r_gx <= gx;
            r_gy <= gy;
        end
    end

    // ------------------------------------------------------------------
    // squares
    // ------------------------------------------------------------------
    logic signed [GRAD_W-1:0] gx_abs, gy_abs;
    logic [2*ABS_W-1:0]       r_gx2, r_gy2;

    assign gx_abs = r_gx[GRAD_W-1] ? -r_gx : r_gx;
    assign gy_abs = r_gy[GRAD_W-1] ? -r_gy : r_gy;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SQUARE) begin
            r_gx2 <= gx_abs[ABS_W-1:0] * gx_abs[ABS_W-1:0];
            r_gy2 <= gy_abs[ABS_W-1:0] * gy_abs[ABS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // squared magnitude and frame statistics
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] sq;
    logic [SQ_W-1:0] r_sq;
    logic [SQ_W-1:0] r_max, r_min, n_max, n_min;
    logic            r_seen, n_seen;
    logic [SQ_W-1:0] r_res_max, r_res_min;

    assign sq = SQ_W'(r_gx2) + SQ_W'(r_gy2);

    // a zero square leaves both the minimum and the maximum alone
    always_comb begin
        n_max  = r_max;
        n_min  = r_min;
        n_seen = r_seen;
        if (sq != '0) begin
            if (sq >= r_max) begin
                n_max = sq;
                if (!r_seen) begin
                    n_min  = sq;
                    n_seen = 1'b1;
                end
            end else if (sq < r_min) begin
                n_min = sq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= '0;
            r_min  <= '0;
            r_seen <= 1'b0;
        end else if ((item_read && r_item_fend && !r_item_emit) ||
                     (root_start && r_item_fend)) begin
            r_max  <= '0;
            r_min  <= '0;
            r_seen <= 1'b0;
        end else if (root_start) begin
            r_max  <= n_max;
            r_min  <= n_min;
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (root_start) begin
            r_sq      <= sq;
            r_res_max <= n_max;
            r_res_min <= n_min;
        end
    end

    // ------------------------------------------------------------------
    // square root
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] root;

    sgm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (sq),
        .o_done     (root_done),
        .o_root     (root)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [COL_X_W-1:0] col_off;
    logic [ROW_X_W-1:0] row_off;

    assign col_off = COL_X_W'(r_item_col) - COL_X_W'(WIN_SIZE - 1);
    assign row_off = ROW_X_W'(r_item_row) - ROW_X_W'(WIN_SIZE - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out_row       <= row_off[POS_W-1:0];
            o_out_col       <= col_off[POS_W-1:0];
            o_grad_x        <= r_gx;
            o_grad_y        <= r_gy;
            o_mag_squared   <= r_sq;
            o_magnitude     <= root;
            o_frame_max_sq  <= r_res_max;
            o_frame_min_sq  <= r_res_min;
            o_last_of_frame <= r_item_fend;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule : sobel_gradient_magnitude_unit
`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression bench for sobel_gradient_magnitude_unit
// Streams raster pixels through the unit under random idling on both sides,
// predicts every 3x3 window result (gradients, squared magnitude, integer
// root, per-frame max / min-nonzero) and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgm_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_PIXELS = 900;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PRINT_LIMIT   = 100;

    typedef enum int {
        PAT_NOISE,
        PAT_BINARY,
        PAT_FLAT,
        PAT_GENTLE
    } t_pattern;

    typedef struct {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [GRAD_W-1:0] gx;
        logic [GRAD_W-1:0] gy;
        logic [SQ_W-1:0]   sq;
        logic [MAG_W-1:0]  mag;
        logic [SQ_W-1:0]   fmax;
        logic [SQ_W-1:0]   fmin;
        logic              last;
    } t_window_result;

    // bench-side signals
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   pix_valid = 1'b0;
    logic [PIX_W-1:0]       pixel = '0;
    logic                   res_stall = 1'b0;

    logic                     o_cfg_ready;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic [POS_W-1:0]         o_out_row;
    logic [POS_W-1:0]         o_out_col;
    logic signed [GRAD_W-1:0] o_grad_x;
    logic signed [GRAD_W-1:0] o_grad_y;
    logic [SQ_W-1:0]          o_mag_squared;
    logic [MAG_W-1:0]         o_magnitude;
    logic [SQ_W-1:0]          o_frame_max_sq;
    logic [SQ_W-1:0]          o_frame_min_sq;
    logic                     o_last_of_frame;

    logic [PIX_W-1:0] pixel_q [$];
    t_window_result   window_q [$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    // predicted block state
    logic [CFG_DATA_W-1:0] geom_width  = RST_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] geom_height = RST_FRAME_HEIGHT;
    logic [PIX_W-1:0]      row_above [DEF_MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0]      row_above2 [DEF_MAX_WIDTH] = '{default: '0};
    logic [PIX_W-1:0]      win_left [WIN_SIZE] = '{default: '0};
    logic [PIX_W-1:0]      win_mid [WIN_SIZE] = '{default: '0};
    int                    cur_row = 0;
    int                    cur_col = 0;
    logic [SQ_W-1:0]       peak_sq = '0;
    logic [SQ_W-1:0]       least_sq = '0;
    logic                  least_seen = 1'b0;

    sobel_gradient_magnitude_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (pix_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel        (pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (res_stall),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_grad_x       (o_grad_x),
        .o_grad_y       (o_grad_y),
        .o_mag_squared  (o_mag_squared),
        .o_magnitude    (o_magnitude),
        .o_frame_max_sq (o_frame_max_sq),
        .o_frame_min_sq (o_frame_min_sq),
        .o_last_of_frame(o_last_of_frame)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int clamp_dim(logic [CFG_DATA_W-1:0] v, int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // floor square root, one result bit at a time from the top
    function automatic logic [MAG_W-1:0] int_root(logic [SQ_W-1:0] v);
        logic [MAG_W-1:0] r;
        logic [MAG_W-1:0] trial;
        r = '0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            trial = r | (MAG_W'(1) << b);
            if (int'(trial) * int'(trial) <= int'(v)) r = trial;
        end
        return r;
    endfunction

    // advance the window by one pixel and queue the window result it completes
    function automatic void sobel_step(logic [PIX_W-1:0] px);
        int w, h, c, r, gx, gy, ax, ay;
        logic [PIX_W-1:0] top, mid;
        logic [SQ_W-1:0] sq;
        logic row_done, frame_done;
        t_window_result res;
        w = clamp_dim(geom_width, DEF_MAX_WIDTH);
        h = clamp_dim(geom_height, DEF_MAX_HEIGHT);
        c = cur_col;
        r = cur_row;
        top = row_above2[c];
        mid = row_above[c];
        row_above2[c] = row_above[c];
        row_above[c] = px;

        // right column minus left column, bottom row minus top row
        gx = (int'(top) + 2 * int'(mid) + int'(px))
           - (int'(win_left[0]) + 2 * int'(win_left[1]) + int'(win_left[2]));
        gy = (int'(win_left[2]) + 2 * int'(win_mid[2]) + int'(px))
           - (int'(win_left[0]) + 2 * int'(win_mid[0]) + int'(top));
        win_left = win_mid;
        win_mid[0] = top;
        win_mid[1] = mid;
        win_mid[2] = px;

        row_done = (c + 1 >= w);
        frame_done = row_done && (r + 1 >= h);

        if (r >= 2 && c >= 2 && c < w && r < h) begin
            ax = (gx < 0) ? -gx : gx;
            ay = (gy < 0) ? -gy : gy;
            sq = SQ_W'(ax * ax + ay * ay);
            // zero magnitude leaves the minimum alone
            if (sq != 0) begin
                if (sq >= peak_sq) begin
                    peak_sq = sq;
                    if (!least_seen) begin
                        least_sq = sq;
                        least_seen = 1'b1;
                    end
                end else if (sq < least_sq) begin
                    least_sq = sq;
                end
            end
            res.row  = POS_W'(r - 2);
            res.col  = POS_W'(c - 2);
            res.gx   = GRAD_W'(gx);
            res.gy   = GRAD_W'(gy);
            res.sq   = sq;
            res.mag  = int_root(sq);
            res.fmax = peak_sq;
            res.fmin = least_sq;
            res.last = frame_done;
            window_q.push_back(res);
        end

        if (frame_done) begin
            cur_row = 0;
            cur_col = 0;
            peak_sq = '0;
            least_sq = '0;
            least_seen = 1'b0;
        end else if (row_done) begin
            cur_col = 0;
            cur_row = r + 1;
        end else begin
            cur_col = c + 1;
        end
    endfunction

    task automatic flag(string msg);
        // keep the log short if the block is badly broken
        if (fail_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string tag, string name, logic [SQ_W-1:0] got,
                               logic [SQ_W-1:0] want);
        if (got !== want) flag($sformatf("%s %s got %0d want %0d", tag, name, got, want));
    endtask

    // pixel driver
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_valid <= 1'b0;
        end else begin
            if (pix_valid && !o_in_stall) sobel_step(pixel);
            if (!pix_valid || !o_in_stall) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    pix_valid <= 1'b1;
                    pixel <= pixel_q.pop_front();
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk) begin
        t_window_result want;
        string tag;
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (o_out_valid && !res_stall) begin
                if (window_q.size() == 0) begin
                    flag($sformatf("result beat at row %0d col %0d with nothing expected",
                                   o_out_row, o_out_col));
                end else begin
                    want = window_q.pop_front();
                    tag = $sformatf("window r%0d c%0d:", want.row, want.col);
                    check_field(tag, "out_row", SQ_W'(o_out_row), SQ_W'(want.row));
                    check_field(tag, "out_col", SQ_W'(o_out_col), SQ_W'(want.col));
                    check_field(tag, "grad_x", SQ_W'(unsigned'(o_grad_x)), SQ_W'(want.gx));
                    check_field(tag, "grad_y", SQ_W'(unsigned'(o_grad_y)), SQ_W'(want.gy));
                    check_field(tag, "mag_squared", o_mag_squared, want.sq);
                    check_field(tag, "magnitude", SQ_W'(o_magnitude), SQ_W'(want.mag));
                    check_field(tag, "frame_max_sq", o_frame_max_sq, want.fmax);
                    check_field(tag, "frame_min_sq", o_frame_min_sq, want.fmin);
                    check_field(tag, "last_of_frame", SQ_W'(o_last_of_frame),
                                SQ_W'(want.last));
                end
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog: cycles without any beat on any channel
    always @(posedge clk) begin
        if (!rst_n || (pix_valid && !o_in_stall) || (o_out_valid && !res_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sobel_gradient_magnitude_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH) geom_width = val;
        else if (idx == REG_FRAME_HEIGHT) geom_height = val;
    endtask

    // wait for the unit to go quiet, then give a pixel with no result time to finish
    // (sampled at the falling edge, once the driver and monitor have settled)
    task automatic drain();
        do @(negedge clk);
        while (pixel_q.size() != 0 || pix_valid || window_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // hand-built first frame: steps, flat areas, a faint gradient, then random pixels
    function automatic logic [PIX_W-1:0] probe_pixel(int row, int col);
        if (col < 6)  return 8'h00;
        if (col < 12) return 8'hFF;
        if (col < 18) return 8'h00;
        if (col < 24) return (row == 0) ? 8'h00 : ((row == 2) ? 8'hFF : 8'h80);
        if (col < 30) return (row == 0) ? 8'hFF : ((row == 2) ? 8'h00 : 8'h80);
        if (col < 36) return (row == 2 && col == 33) ? 8'h65 : 8'h64;
        return PIX_W'($urandom_range(255));
    endfunction

    function automatic logic [PIX_W-1:0] pattern_pixel(t_pattern kind, logic [PIX_W-1:0] base);
        case (kind)
            PAT_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
            PAT_FLAT:   return base;
            PAT_GENTLE: return base + PIX_W'($urandom_range(2));
            default:    return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim(int mode);
        case (mode)
            0: return $urandom_range(1) ? CFG_DATA_W'($urandom_range(2))
                                         : CFG_DATA_W'($urandom_range(65, 127));
            1: return CFG_DATA_W'($urandom_range(9, 64));
            2: return CFG_DATA_W'($urandom_range(3, 4));
            default: return CFG_DATA_W'($urandom_range(3, 8));
        endcase
    endfunction

    // stimulus
    initial begin
        int sent, sel, w, h, area, count, chunk;
        logic [CFG_DATA_W-1:0] wv, hv;
        t_pattern kind;
        logic [PIX_W-1:0] base;

        send_idle_pct  = 14;
        recv_stall_pct = 64;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // full-width frame first, so every line store entry holds a pixel
        write_reg(REG_FRAME_WIDTH, 7'd64);
        write_reg(REG_FRAME_HEIGHT, 7'd3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < DEF_MAX_WIDTH; c++) pixel_q.push_back(probe_pixel(r, c));
        drain();

        // narrowest, tallest frame through clamped values; unused indexes ignored
        write_reg(REG_FRAME_WIDTH, 7'd0);
        write_reg(REG_FRAME_HEIGHT, 7'd127);
        write_reg(CFG_INDEX_W'(2), 7'h7F);
        write_reg(CFG_INDEX_W'(3), 7'h00);
        repeat (3 * DEF_MAX_HEIGHT) pixel_q.push_back(pattern_pixel(PAT_BINARY, '0));
        drain();

        // all-black minimum frame: no gradient anywhere
        write_reg(REG_FRAME_HEIGHT, 7'd3);
        repeat (9) pixel_q.push_back(8'h00);

        // random frames, partial frames leave geometry changes mid-frame
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            drain();
            if (sent < RANDOM_PIXELS / 3) begin
                send_idle_pct  = 14;
                recv_stall_pct = 64;
            end else if (sent < 2 * RANDOM_PIXELS / 3) begin
                send_idle_pct  = 64;
                recv_stall_pct = 14;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            sel = $urandom_range(99);
            if (sel < 4) begin
                wv = pick_dim(0);
                hv = pick_dim(2);
            end else if (sel < 8) begin
                wv = pick_dim(2);
                hv = pick_dim(0);
            end else if (sel < 11) begin
                wv = pick_dim(1);
                hv = pick_dim(2);
            end else if (sel < 14) begin
                wv = pick_dim(2);
                hv = pick_dim(1);
            end else begin
                wv = pick_dim(3);
                hv = CFG_DATA_W'($urandom_range(3, 6));
            end
            if ($urandom_range(5) != 0) write_reg(REG_FRAME_WIDTH, wv);
            if ($urandom_range(5) != 0) write_reg(REG_FRAME_HEIGHT, hv);
            if ($urandom_range(7) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom));

            w = clamp_dim(geom_width, DEF_MAX_WIDTH);
            h = clamp_dim(geom_height, DEF_MAX_HEIGHT);
            area = w * h;
            if ($urandom_range(4) == 0) count = $urandom_range(1, area);
            else if (area > 60) count = area;
            else count = area * $urandom_range(1, 3);

            sent += count;
            while (count > 0) begin
                chunk = (count < area) ? count : area;
                kind = t_pattern'($urandom_range(3));
                base = PIX_W'($urandom_range(255));
                repeat (chunk) pixel_q.push_back(pattern_pixel(kind, base));
                count -= chunk;
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("sobel_gradient_magnitude_unit regression: pass");
        end else begin
            $display("sobel_gradient_magnitude_unit regression: fail");
        end
        $finish;
    end

endmodule : tb

// ===== filelist.f =====
hdl/sgm_pkg.sv
hdl/sgm_isqrt.sv
hdl/sobel_gradient_magnitude_unit.sv
bench/tb.sv
